// ===== rtl/ppl_pkg.sv =====
// shared constants and types for the polyline path length block
package ppl_pkg;

	localparam int COORD_W   = 16;
	localparam int FRAC_BITS = 8;
	localparam int SUM_W     = 40;

	// magnitude of a coordinate difference needs one bit more than a coordinate
	localparam int MAG_W  = COORD_W + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int RAD_W  = SQ_W + 2 * FRAC_BITS;
	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;
	localparam int CNT_W  = $clog2(ROOT_W);

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic [ROOT_W-1:0]         root_t;
	typedef logic [SUM_W-1:0]          sum_t;

	localparam sum_t SUM_MAX = {SUM_W{1'b1}};

endpackage

// ===== rtl/ppl_sqdist.sv =====
// squared distance between two points, one shared multiplier for both squares
module ppl_sqdist (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  ppl_pkg::coord_t cur_x,
	input  ppl_pkg::coord_t cur_y,
	input  ppl_pkg::coord_t prev_x,
	input  ppl_pkg::coord_t prev_y,
	output logic           done,
	output ppl_pkg::sq_t   sq
);
	import ppl_pkg::*;

	typedef enum logic [3:0] {
		SD_IDLE = 4'b0001,
		SD_SQX  = 4'b0010,
		SD_SQY  = 4'b0100,
		SD_SUM  = 4'b1000
	} sd_state_t;

	sd_state_t state_q;
	mag_t      ax_q;
	mag_t      ay_q;
	sq_t       mul_q;
	sq_t       part_q;

	logic signed [MAG_W-1:0] dx;
	logic signed [MAG_W-1:0] dy;
	mag_t                    ax;
	mag_t                    ay;
	mag_t                    op;

	assign dx = {cur_x[COORD_W-1], cur_x} - {prev_x[COORD_W-1], prev_x};
	assign dy = {cur_y[COORD_W-1], cur_y} - {prev_y[COORD_W-1], prev_y};
	// the most negative difference negates to its own pattern, correct as unsigned
	assign ax = dx[MAG_W-1] ? mag_t'(-dx) : mag_t'(dx);
	assign ay = dy[MAG_W-1] ? mag_t'(-dy) : mag_t'(dy);
	assign op = (state_q == SD_SQX) ? ax_q : ay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SD_IDLE;
		end else begin
			unique case (state_q)
				SD_IDLE: begin
					if (start) begin
						state_q <= SD_SQX;
					end
				end
				SD_SQX:  state_q <= SD_SQY;
				SD_SQY:  state_q <= SD_SUM;
				SD_SUM:  state_q <= SD_IDLE;
				default: state_q <= SD_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SD_IDLE && start) begin
			ax_q <= ax;
			ay_q <= ay;
		end
		if (state_q == SD_SQX || state_q == SD_SQY) begin
			mul_q <= op * op;
		end
		if (state_q == SD_SQY) begin
			part_q <= mul_q;
		end
	end

	// both squares are at most 2^(2*COORD_W), so the sum fits
	assign sq   = part_q + mul_q;
	assign done = (state_q == SD_SUM);

endmodule

// ===== rtl/ppl_sqrt.sv =====
// serial integer square root, two radicand bits shifted in per cycle
module ppl_sqrt (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ppl_pkg::sq_t  sq,
	output logic          done,
	output ppl_pkg::root_t root
);
	import ppl_pkg::*;

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	root_t            root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] rem_nx;
	logic             ge;

	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = (REM_W+2)'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);
	assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// fraction bits come from zero pairs appended below the square
			rad_q  <= {sq, {(2*FRAC_BITS){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= REM_W'(rem_nx);
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== rtl/polyline_path_length_top.sv =====
// top level: point intake, distance sequencing, saturating sum and result register
//
// Points arrive one per transfer; every point after the first of a path adds
// floor(sqrt(dx*dx + dy*dy) * 256) to a 40-bit unsigned Q.8 sum that clamps at
// its maximum and sets length_saturated. The point marked path_end produces one
// result transfer with the total and clears the block for a new path; a
// one-point path reports 0. A first point goes straight to hand-off; every later
// point has both differences taken and squared on one shared multiplier, runs
// the serial square root (one result bit per cycle over the 50-bit scaled
// radicand), then is accumulated; the next point is taken only after hand-off.
// A finished result waits in its own output register, so the next point is
// taken while the result is still stalled.
module polyline_path_length_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ppl_pkg::coord_t coord_x,
	input  ppl_pkg::coord_t coord_y,
	input  logic            path_end,
	output logic            out_valid,
	input  logic            out_stall,
	output ppl_pkg::sum_t   path_length,
	output logic            length_saturated
);
	import ppl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_START = 4'b0010,
		ST_DIST  = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	coord_t cur_x_q;
	coord_t cur_y_q;
	logic   end_q;
	coord_t prev_x_q;
	coord_t prev_y_q;
	logic   have_prev_q;
	sum_t   length_sum_q;
	logic   sum_sat_q;
	logic   out_valid_q;
	sum_t   out_len_q;
	logic   out_sat_q;

	logic   in_xfer;
	logic   sd_done;
	sq_t    sd_sq;
	logic   sq_done;
	root_t  sq_root;
	logic   emit_go;
	logic [SUM_W:0] sum_ext;

	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign emit_go  = (state_q == ST_EMIT) && (!end_q || !out_valid_q || !out_stall);
	assign sum_ext  = {1'b0, length_sum_q} + (SUM_W+1)'(sq_root);

	ppl_sqdist u_sqdist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_START),
		.cur_x  (cur_x_q),
		.cur_y  (cur_y_q),
		.prev_x (prev_x_q),
		.prev_y (prev_y_q),
		.done   (sd_done),
		.sq     (sd_sq)
	);

	ppl_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sd_done),
		.sq     (sd_sq),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			have_prev_q  <= 1'b0;
			length_sum_q <= '0;
			sum_sat_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= have_prev_q ? ST_START : ST_EMIT;
					end
				end
				ST_START: state_q <= ST_DIST;
				ST_DIST: begin
					if (sq_done) begin
						// saturate when the sum reaches or passes the maximum
						if (sum_ext >= (SUM_W+1)'(SUM_MAX)) begin
							length_sum_q <= SUM_MAX;
							sum_sat_q    <= 1'b1;
						end else begin
							length_sum_q <= SUM_W'(sum_ext);
						end
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
						if (end_q) begin
							prev_x_q     <= '0;
							prev_y_q     <= '0;
							have_prev_q  <= 1'b0;
							length_sum_q <= '0;
							sum_sat_q    <= 1'b0;
						end else begin
							prev_x_q    <= cur_x_q;
							prev_y_q    <= cur_y_q;
							have_prev_q <= 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (emit_go && end_q) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cur_x_q <= coord_x;
			cur_y_q <= coord_y;
			end_q   <= path_end;
		end
		if (emit_go && end_q) begin
			out_len_q <= length_sum_q;
			out_sat_q <= sum_sat_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign path_length      = out_len_q;
	assign length_saturated = out_sat_q;

	// the root unit only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> (state_q == ST_DIST))
		else $error("root finished outside distance wait");

	// a new result only comes from the last point of a path
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EMIT && end_q))
		else $error("result raised without a path end");

	// a saturated path holds the sum at its maximum
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_sat_q |-> (length_sum_q == SUM_MAX))
		else $error("saturation flag without clamped sum");

	// the first point of a path skips the distance work
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !have_prev_q) |=> (state_q == ST_EMIT))
		else $error("first point entered distance work");

endmodule
